// ----- sv/tsk_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsk_pkg
// shared constants and types for the task scheduler
// ----------------------------------------------------------------------------
package tsk_pkg;

  localparam int TASK_SLOTS = 8;
  localparam int SLOT_W = $clog2(TASK_SLOTS);
  localparam int TOTAL_W = $clog2(TASK_SLOTS + 1);
  localparam logic [15:0] WATCHDOG_LIMIT = 16'd30000;

  localparam logic [2:0] OP_TICK      = 3'd0;
  localparam logic [2:0] OP_SCHEDULE  = 3'd1;
  localparam logic [2:0] OP_CREATE    = 3'd2;
  localparam logic [2:0] OP_SET_DELAY = 3'd3;
  localparam logic [2:0] OP_SET_WAIT  = 3'd4;
  localparam logic [2:0] OP_SET_PAUSE = 3'd5;
  localparam logic [2:0] OP_FEED      = 3'd6;

  typedef struct packed {
    logic             load;
    logic             tick_slot;
    logic             sched_slot;
    logic             sched_done;
    logic [SLOT_W-1:0] slot;
  } tsk_cmd_t;

  typedef struct packed {
    logic [TOTAL_W-1:0] task_total;
    logic [SLOT_W-1:0]  running_slot;
  } tsk_status_t;

endpackage

// ----- sv/task_scheduler_with_tick.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// task_scheduler_with_tick
// round-robin task table with periodic tick and watchdog
// ----------------------------------------------------------------------------
// usage:
//   input channel in_valid/in_stall carries one operation per transaction
//   (tick, schedule, create, set delay, set wait, set paused, feed)
//   output channel out_valid/out_stall returns one result per transaction
//   kernel_running is written through cfg_we/cfg_data; the user writes it
//   only while idle, as the block itself does not enforce this
//   tick and schedule with a nonempty table walk the slots, one slot per
//   cycle through the shared update logic, before out_valid rises; every
//   other case skips the walk
// throughput: one transaction at a time, the next one accepted the cycle
//   after the result is taken
// reset: synchronous rst clears the task table, the counters and the
//   controller; no transaction is pending afterwards
// a stalled result holds its value and in_stall stays high until taken
// ----------------------------------------------------------------------------
module task_scheduler_with_tick import tsk_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  operation,
  input  logic [2:0]  task_index,
  input  logic [15:0] amount,
  input  logic [2:0]  wait_kinds,
  input  logic        pause_flag,
  input  logic [7:0]  mutex_busy_mask,
  input  logic [7:0]  event_one_clear_mask,
  input  logic [7:0]  event_two_clear_mask,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  current_task,
  output logic        switch_needed,
  output logic        create_ok,
  output logic [3:0]  created_number,
  output logic        reset_request
);

  logic        kernel_running;
  tsk_cmd_t    cmd;
  tsk_status_t status;

  always_ff @(posedge clk) begin
    if (rst) kernel_running <= 1'b0;
    else if (cfg_we) kernel_running <= cfg_data;
  end

  tsk_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .operation(operation), .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .cmd(cmd)
  );

  tsk_datapath u_dp (
    .clk(clk), .rst(rst), .kernel_running(kernel_running), .cmd(cmd),
    .operation(operation), .task_index(task_index), .amount(amount),
    .wait_kinds(wait_kinds), .pause_flag(pause_flag),
    .mutex_busy_mask(mutex_busy_mask), .event_one_clear_mask(event_one_clear_mask),
    .event_two_clear_mask(event_two_clear_mask), .status(status),
    .current_task(current_task), .switch_needed(switch_needed),
    .create_ok(create_ok), .created_number(created_number),
    .reset_request(reset_request)
  );

endmodule

// ----- sv/tsk_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsk_datapath
// task table, per-slot tick update, schedule search and result register
// ----------------------------------------------------------------------------
module tsk_datapath import tsk_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              kernel_running,
  input  tsk_cmd_t          cmd,
  input  logic [2:0]        operation,
  input  logic [2:0]        task_index,
  input  logic [15:0]       amount,
  input  logic [2:0]        wait_kinds,
  input  logic              pause_flag,
  input  logic [7:0]        mutex_busy_mask,
  input  logic [7:0]        event_one_clear_mask,
  input  logic [7:0]        event_two_clear_mask,
  output tsk_status_t       status,
  output logic [2:0]        current_task,
  output logic              switch_needed,
  output logic              create_ok,
  output logic [3:0]        created_number,
  output logic              reset_request
);

  logic [TOTAL_W-1:0] task_total;
  logic [SLOT_W-1:0]  running_slot;
  logic               running_valid;
  logic [15:0]        delay_left [TASK_SLOTS];
  logic [15:0]        timeout_left [TASK_SLOTS];
  logic [2:0]         waiting_on [TASK_SLOTS];
  logic [TASK_SLOTS-1:0] paused;
  logic [15:0]        watchdog_count [TASK_SLOTS];

  logic [2:0]  op_r;
  logic [SLOT_W-1:0] idx_r;
  logic [15:0] amount_r;
  logic [2:0]  kinds_r;
  logic        pause_r;
  logic [7:0]  mb_r, e1_r, e2_r;
  logic        found;
  logic [SLOT_W-1:0] chosen;

  logic [2:0]  mask3;
  logic        blocked;
  logic [15:0] wd_inc;
  logic        idx_ok;

  always_comb begin
    mask3 = 3'b000;
    if (TOTAL_W'(cmd.slot) < TOTAL_W'(8)) begin
      mask3 = {e2_r[cmd.slot[2:0]], e1_r[cmd.slot[2:0]], mb_r[cmd.slot[2:0]]};
    end
    blocked = |(waiting_on[cmd.slot] & mask3) || (delay_left[cmd.slot] != 16'd0)
              || paused[cmd.slot];
    wd_inc = (watchdog_count[cmd.slot] != 16'hFFFF) ? watchdog_count[cmd.slot] + 16'd1
                                                     : watchdog_count[cmd.slot];
    idx_ok = TOTAL_W'(idx_r) < task_total;
  end

  assign status.task_total = task_total;
  assign status.running_slot = running_slot;

  always_ff @(posedge clk) begin
    if (rst) begin
      task_total <= '0;
      running_slot <= '0;
      running_valid <= 1'b0;
      paused <= '0;
      current_task <= '0;
      switch_needed <= 1'b0;
      create_ok <= 1'b0;
      created_number <= '0;
      reset_request <= 1'b0;
      found <= 1'b0;
      chosen <= '0;
      for (int i = 0; i < TASK_SLOTS; i++) begin
        delay_left[i] <= '0;
        timeout_left[i] <= '0;
        waiting_on[i] <= '0;
        watchdog_count[i] <= '0;
      end
    end else begin
      if (cmd.load) begin
        op_r <= operation;
        idx_r <= SLOT_W'(task_index);
        amount_r <= amount;
        kinds_r <= wait_kinds;
        pause_r <= pause_flag;
        mb_r <= mutex_busy_mask;
        e1_r <= event_one_clear_mask;
        e2_r <= event_two_clear_mask;
        found <= 1'b0;
        chosen <= '0;
        switch_needed <= 1'b0;
        create_ok <= 1'b0;
        created_number <= '0;
        reset_request <= 1'b0;
        if (operation == OP_TICK && kernel_running && task_total == '0) begin
          reset_request <= 1'b1;
        end
      end
      if (cmd.tick_slot) begin
        if (delay_left[cmd.slot] != 16'd0) begin
          delay_left[cmd.slot] <= delay_left[cmd.slot] - 16'd1;
        end
        if (timeout_left[cmd.slot] != 16'd0) begin
          timeout_left[cmd.slot] <= timeout_left[cmd.slot] - 16'd1;
          if (timeout_left[cmd.slot] == 16'd1) begin
            waiting_on[cmd.slot] <= '0;
          end
        end
        watchdog_count[cmd.slot] <= wd_inc;
        if (wd_inc > WATCHDOG_LIMIT) begin
          reset_request <= 1'b1;
        end
      end
      if (cmd.sched_slot && !blocked && !found) begin
        found <= 1'b1;
        chosen <= cmd.slot;
      end
      if (cmd.sched_done) begin
        case (op_r)
          OP_SCHEDULE: begin
            if (task_total != '0 && running_valid) begin
              switch_needed <= chosen != running_slot;
              running_slot <= chosen;
              current_task <= 3'(chosen);
            end else begin
              current_task <= 3'(running_slot);
            end
          end
          OP_CREATE: begin
            if (task_total < TOTAL_W'(TASK_SLOTS)) begin
              task_total <= task_total + 1'b1;
              create_ok <= 1'b1;
              created_number <= 4'(task_total + 1'b1);
              if (!running_valid) begin
                running_slot <= SLOT_W'(task_total);
                running_valid <= 1'b1;
                current_task <= 3'(task_total);
              end else begin
                current_task <= 3'(running_slot);
              end
            end else begin
              current_task <= 3'(running_slot);
            end
          end
          OP_SET_DELAY: begin
            if (idx_ok) delay_left[idx_r] <= amount_r;
            current_task <= 3'(running_slot);
          end
          OP_SET_WAIT: begin
            if (idx_ok) begin
              waiting_on[idx_r] <= kinds_r;
              timeout_left[idx_r] <= amount_r;
            end
            current_task <= 3'(running_slot);
          end
          OP_SET_PAUSE: begin
            if (idx_ok) paused[idx_r] <= pause_r;
            current_task <= 3'(running_slot);
          end
          OP_FEED: begin
            if (kernel_running && running_valid) watchdog_count[running_slot] <= '0;
            current_task <= 3'(running_slot);
          end
          default: begin
            current_task <= 3'(running_slot);
          end
        endcase
      end
    end
  end

endmodule

// ----- sv/tsk_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsk_ctrl
// sequencer: accepts a transaction, walks the slots, holds the result
// ----------------------------------------------------------------------------
module tsk_ctrl import tsk_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  operation,
  output logic        out_valid,
  input  logic        out_stall,
  input  tsk_status_t status,
  output tsk_cmd_t    cmd
);

  typedef enum logic [1:0] {S_IDLE, S_WALK, S_DONE, S_OUT} state_t;

  state_t state;
  logic [2:0] op;
  logic [TOTAL_W-1:0] count;
  logic [SLOT_W-1:0] slot;
  logic accept;

  assign in_stall = !(state == S_IDLE);
  assign accept = in_valid && state == S_IDLE;

  always_comb begin
    cmd.load = accept;
    cmd.slot = slot;
    cmd.tick_slot = state == S_WALK && op == OP_TICK;
    cmd.sched_slot = state == S_WALK && op == OP_SCHEDULE;
    cmd.sched_done = state == S_DONE;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      op <= OP_TICK;
      count <= '0;
      slot <= '0;
      out_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            op <= operation;
            count <= '0;
            if (operation == OP_SCHEDULE) begin
              slot <= (TOTAL_W'(status.running_slot) + 1'b1 >= status.task_total)
                      ? '0 : status.running_slot + 1'b1;
            end else begin
              slot <= '0;
            end
            if ((operation == OP_TICK || operation == OP_SCHEDULE)
                && status.task_total != '0) begin
              state <= S_WALK;
            end else begin
              state <= S_DONE;
            end
          end
        end
        S_WALK: begin
          count <= count + 1'b1;
          if (TOTAL_W'(slot) + 1'b1 >= status.task_total) slot <= '0;
          else slot <= slot + 1'b1;
          if (count + 1'b1 >= status.task_total) state <= S_DONE;
        end
        S_DONE: begin
          out_valid <= 1'b1;
          state <= S_OUT;
        end
        S_OUT: begin
          if (!out_stall) begin
            out_valid <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
